FILE: rtl/sli_pkg.sv
// sli_pkg: shared types and codes for the sorted list insert/delete block.
// No dependencies; used by sli_cell and sorted_list_insert_delete.

package sli_pkg;

	localparam int DATA_W   = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;

	// input item kinds
	localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LIST = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

	// operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		OP_HOLD = 3'd0,
		OP_CMP  = 3'd1,
		OP_INS  = 3'd2,
		OP_DEL  = 3'd3,
		OP_ROT  = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [DATA_W-1:0] key;
	} cell_ctrl_t;

endpackage

FILE: rtl/sli_cell.sv
// sli_cell: one slot of the sorted list chain, holding a value and a valid bit.
// Depends on sli_pkg; instantiated in a row by sorted_list_insert_delete.

module sli_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sli_pkg::cell_ctrl_t           ctrl,
	input  logic [sli_pkg::DATA_W-1:0]    left_value,
	input  logic                          left_valid,
	input  logic                          left_move,
	input  logic [sli_pkg::DATA_W-1:0]    right_value,
	input  logic                          right_valid,
	input  logic [sli_pkg::DATA_W-1:0]    head_value,
	input  logic                          found_in,
	output logic [sli_pkg::DATA_W-1:0]    value,
	output logic                          valid,
	output logic                          move,
	output logic                          found_out
);

	logic [sli_pkg::DATA_W-1:0] value_q;
	logic                       valid_q;
	logic                       gt_q;
	logic                       eq_q;

	// at or past the insertion point: empty, or holding a greater value
	assign move      = !valid_q || gt_q;
	// a match lies here or to the left
	assign found_out = found_in || eq_q;
	assign value     = value_q;
	assign valid     = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			gt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			unique case (ctrl.op)
				sli_pkg::OP_CMP: begin
					gt_q <= valid_q && ($signed(value_q) > $signed(ctrl.key));
					eq_q <= valid_q && (value_q == ctrl.key);
				end
				sli_pkg::OP_INS: begin
					if (move) begin
						valid_q <= left_move ? left_valid : 1'b1;
					end
				end
				sli_pkg::OP_DEL: begin
					if (found_out) begin
						valid_q <= right_valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			sli_pkg::OP_INS: begin
				if (move) begin
					value_q <= left_move ? left_value : ctrl.key;
				end
			end
			sli_pkg::OP_DEL: begin
				if (found_out) begin
					value_q <= right_value;
				end
			end
			sli_pkg::OP_ROT: begin
				// rotate the occupied part one slot toward the head
				if (valid_q) begin
					value_q <= right_valid ? right_value : head_value;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/sorted_list_insert_delete.sv
// sorted_list_insert_delete: bounded ascending list of signed words in a chain of cells.
// Depends on sli_pkg and sli_cell.
//
//  channel | direction | handshake          | contents
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | tuser: kind; tdata: value
//  m_      | out       | m_tvalid/m_tready  | tuser: status; tdata: entry_value; tlast
//
// Add and delete: the accept edge loads compare flags in every cell in parallel; once the
// output register is free, the apply step shifts the chain one slot (unless the list is
// full or the value is absent) and loads the result word. List emits one word per stored
// entry and rotates the chain one slot per word, so it ends in its original order.
// Reset empties the list at once (valid bits cleared); no sweep is needed.
// A stalled output register holds the machine in its apply or list step; a new
// input word is taken while the last result of the previous item still waits.

module sorted_list_insert_delete #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] entry_value
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = sli_pkg::DATA_W;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_APPLY = 3'b010,
		S_LIST  = 3'b100
	} state_t;

	state_t                        state_q;
	logic [sli_pkg::KIND_W-1:0]    kind_q;
	logic [DW-1:0]                 key_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 rem_q;

	logic                          out_valid_q;
	logic [sli_pkg::STATUS_W-1:0]  out_status_q;
	logic [DW-1:0]                 out_value_q;
	logic                          out_last_q;

	sli_pkg::cell_ctrl_t           ctrl;
	logic [DW-1:0]                 value_w [CAPACITY];
	logic [CAPACITY-1:0]           valid_w;
	logic [CAPACITY-1:0]           move_w;
	logic [CAPACITY-1:0]           found_w;

	logic                          accept;
	logic                          out_free;
	logic                          full;
	logic                          found;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign full     = (count_q == CW'(CAPACITY));
	assign found    = found_w[CAPACITY-1];

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	// Cell command: compare against the incoming word on accept, then shift or rotate.
	always_comb begin
		ctrl.op  = sli_pkg::OP_HOLD;
		ctrl.key = key_q;
		priority if (accept) begin
			ctrl.op  = sli_pkg::OP_CMP;
			ctrl.key = s_tdata;
		end else if (state_q == S_APPLY && out_free) begin
			if (kind_q == sli_pkg::KIND_ADD && !full) begin
				ctrl.op = sli_pkg::OP_INS;
			end else if (kind_q == sli_pkg::KIND_DEL && found) begin
				ctrl.op = sli_pkg::OP_DEL;
			end
		end else if (state_q == S_LIST && out_free) begin
			ctrl.op = sli_pkg::OP_ROT;
		end
	end

	// The chain: slot 0 holds the smallest value.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DW-1:0] lv;
		logic          lval;
		logic          lmove;
		logic          fin;
		logic [DW-1:0] rv;
		logic          rval;

		if (i == 0) begin : g_head
			assign lv    = '0;
			assign lval  = 1'b0;
			assign lmove = 1'b0;
			assign fin   = 1'b0;
		end else begin : g_body
			assign lv    = value_w[i-1];
			assign lval  = valid_w[i-1];
			assign lmove = move_w[i-1];
			assign fin   = found_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rv   = '0;
			assign rval = 1'b0;
		end else begin : g_inner
			assign rv   = value_w[i+1];
			assign rval = valid_w[i+1];
		end

		sli_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_value  (lv),
			.left_valid  (lval),
			.left_move   (lmove),
			.right_value (rv),
			.right_valid (rval),
			.head_value  (value_w[0]),
			.found_in    (fin),
			.value       (value_w[i]),
			.valid       (valid_w[i]),
			.move        (move_w[i]),
			.found_out   (found_w[i])
		);
	end

	// Sequencer and occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (out_free) begin
						// a non-empty list walks the chain; everything else is done
						if (kind_q == sli_pkg::KIND_LIST && count_q != '0) begin
							rem_q   <= count_q;
							state_q <= S_LIST;
						end else begin
							state_q <= S_IDLE;
						end
						if (kind_q == sli_pkg::KIND_ADD && !full) begin
							count_q <= count_q + CW'(1);
						end else if (kind_q == sli_pkg::KIND_DEL && found) begin
							count_q <= count_q - CW'(1);
						end
					end
				end
				S_LIST: begin
					if (out_free) begin
						rem_q <= rem_q - CW'(1);
						if (rem_q == CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Latch the item on accept; payload, no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			key_q  <= s_tdata;
		end
	end

	// Output register: load a result word, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_APPLY && out_free) begin
			out_valid_q <= (kind_q == sli_pkg::KIND_ADD) || (kind_q == sli_pkg::KIND_DEL) ||
			               (kind_q == sli_pkg::KIND_LIST && count_q == '0);
		end else if (state_q == S_LIST && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_APPLY && out_free) begin
			out_value_q <= key_q;
			out_last_q  <= 1'b1;
			unique case (kind_q)
				sli_pkg::KIND_ADD:  out_status_q <= full ? sli_pkg::ST_FULL : sli_pkg::ST_ADDED;
				sli_pkg::KIND_DEL:  out_status_q <= found ? sli_pkg::ST_DELETED
				                                          : sli_pkg::ST_NOT_FOUND;
				default:            out_status_q <= sli_pkg::ST_EMPTY;
			endcase
		end else if (state_q == S_LIST && out_free) begin
			out_value_q  <= value_w[0];
			out_status_q <= sli_pkg::ST_ENTRY;
			out_last_q   <= (rem_q == CW'(1));
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_w & (valid_w + CAPACITY'(1))) == '0 && $countones(valid_w) == int'(count_q))
		else $error("valid bits not a packed prefix matching the count");

	a_accept_apply: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_APPLY)
		else $error("accepted word did not move to apply");

	a_list_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIST |-> rem_q != '0 && rem_q <= count_q)
		else $error("list remainder out of range");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && valid_w[1] |-> !($signed(value_w[0]) > $signed(value_w[1])))
		else $error("head slots out of order");
`endif

endmodule
